FILE: hw/rtl/cfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg
// shared constants, codes and controller/datapath interface types for the
// contiguous frame allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

   // frames the block can hold; usable frames are capped at 1024 by the index field
   localparam int FRAMES    = 1024;
   localparam int MAP_DEPTH = (FRAMES < 1024) ? FRAMES : 1024;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);

   localparam int COUNT_W   = 11;
   localparam int INDEX_W   = 10;
   localparam int STATUS_W  = 2;
   localparam int SUM_W     = COUNT_W + 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [COUNT_W-1:0] LIMIT_MAX = COUNT_W'(MAP_DEPTH);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_REQ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUMP_BASE   = 1'd1;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 11'd1024;
   localparam logic [COUNT_W-1:0] BUMP_BASE_RESET   = 11'd0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK,
      ST_FREE_WAIT,
      ST_FILL,
      ST_DONE
   } cfa_state_type;

   typedef enum logic [1:0] {
      RES_ALLOC_OK,
      RES_FREE_OK,
      RES_NO_SPACE,
      RES_BAD_REQ
   } cfa_res_type;

   typedef struct packed {
      logic        clr_step;
      logic        load;
      logic        scan_rd;
      logic        scan_chk;
      logic        take_run;
      logic        take_bump;
      logic        mark_step;
      logic        size_rd;
      logic        fill_init;
      logic        fill_step;
      logic        res_set;
      cfa_res_type res_code;
      logic        rsp_load;
   } cfa_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic op_free;
      logic cnt_zero;
      logic idx_bad;
      logic scan_done;
      logic scan_hit;
      logic bump_fail;
      logic walk_done;
      logic rsp_free;
   } cfa_status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/cfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_ctrl
// sequencer for the frame allocator: clearing pass, first-fit scan, bump
// fallback, run marking, run freeing and response hand-off
// ----------------------------------------------------------------------------
module cfa_ctrl
   import cfa_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire cfa_status_type stat,
   output cfa_cmd_type         cmd
);

   cfa_state_type state_ff;
   cfa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.res_code = RES_ALLOC_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!stat.op_free) begin
               if (stat.cnt_zero) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = RES_BAD_REQ;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end else if (stat.idx_bad) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = RES_BAD_REQ;
               state_in     = ST_DONE;
            end else begin
               cmd.size_rd = 1'b1;
               state_in    = ST_FREE_WAIT;
            end
         end
         ST_SCAN_RD: begin
            if (stat.scan_done) begin
               // no free run: fall back to the bump region, or report no space if the run does not fit there
               if (stat.bump_fail) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = RES_NO_SPACE;
                  state_in     = ST_DONE;
               end else begin
                  cmd.take_bump = 1'b1;
                  state_in      = ST_MARK;
               end
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (stat.scan_hit) begin
               cmd.take_run = 1'b1;
               state_in     = ST_MARK;
            end else begin
               cmd.scan_chk = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_MARK: begin
            if (stat.walk_done) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = RES_ALLOC_OK;
               state_in     = ST_DONE;
            end else begin
               cmd.mark_step = 1'b1;
            end
         end
         ST_FREE_WAIT: begin
            cmd.fill_init = 1'b1;
            state_in      = ST_FILL;
         end
         ST_FILL: begin
            if (stat.walk_done) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = RES_FREE_OK;
               state_in     = ST_DONE;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/cfa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_datapath
// configuration registers, free map and run size memories, scan and walk
// counters, bump pointer and the response register
// ----------------------------------------------------------------------------
module cfa_datapath
   import cfa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfa_cmd_type          cmd,
   output cfa_status_type            stat,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]   csr_write_data,
   input  wire logic                 req_op,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire logic [INDEX_W-1:0]   req_frame_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_ok,
   output logic [INDEX_W-1:0]        rsp_start_frame,
   output logic [STATUS_W-1:0]       rsp_status
);

   logic free_map [MAP_DEPTH];
   logic [COUNT_W-1:0] run_size [MAP_DEPTH];

   logic [COUNT_W-1:0]  frame_count_ff;
   logic [COUNT_W-1:0]  bump_base_ff;
   logic [COUNT_W-1:0]  bumped_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic                op_ff;
   logic [COUNT_W-1:0]  cnt_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [COUNT_W-1:0]  scan_ff;
   logic [COUNT_W-1:0]  run_ff;
   logic [ADDR_W-1:0]   first_ff;
   logic                bit_rd_ff;
   logic [COUNT_W-1:0]  size_rd_ff;
   logic [ADDR_W-1:0]   start_ff;
   logic [COUNT_W-1:0]  walk_ff;
   logic [COUNT_W-1:0]  end_ff;
   logic                res_ok_ff;
   logic [INDEX_W-1:0]  res_start_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [INDEX_W-1:0]  rsp_start_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [COUNT_W-1:0]  lim;
   logic [SUM_W-1:0]    bump_start;
   logic [SUM_W-1:0]    bump_end;
   logic [SUM_W-1:0]    free_end;
   logic [ADDR_W-1:0]   first_now;
   logic [ADDR_W-1:0]   start_value;
   logic                map_we;
   logic [ADDR_W-1:0]   map_wa;
   logic                map_wd;
   logic                size_we;
   logic [ADDR_W-1:0]   size_wa;
   logic [COUNT_W-1:0]  size_wd;

   assign lim        = (frame_count_ff > LIMIT_MAX) ? LIMIT_MAX : frame_count_ff;
   assign bump_start = SUM_W'(bump_base_ff) + SUM_W'(bumped_ff);
   assign bump_end   = bump_start + SUM_W'(cnt_ff);
   assign free_end   = SUM_W'(idx_ff) + SUM_W'(size_rd_ff);
   // a run opens at the current frame when nothing is pending
   assign first_now  = (run_ff == '0) ? scan_ff[ADDR_W-1:0] : first_ff;
   assign start_value = cmd.take_run ? first_now : bump_start[ADDR_W-1:0];

   assign stat.clr_last  = (clr_ff == ADDR_W'(MAP_DEPTH - 1));
   assign stat.op_free   = (op_ff == OP_FREE);
   assign stat.cnt_zero  = (cnt_ff == '0);
   assign stat.idx_bad   = (COUNT_W'(idx_ff) >= lim);
   assign stat.scan_done = (scan_ff >= lim);
   assign stat.scan_hit  = bit_rd_ff && ((run_ff + COUNT_W'(1)) >= cnt_ff);
   assign stat.bump_fail = (bump_end > SUM_W'(lim));
   assign stat.walk_done = (walk_ff >= end_ff);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FRAME_COUNT_RESET;
         bump_base_ff   <= BUMP_BASE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_COUNT: frame_count_ff <= csr_write_data;
            CSR_BUMP_BASE:   bump_base_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         bumped_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
         if (cmd.take_bump) begin
            bumped_ff <= bumped_ff + cnt_ff;
         end
      end
   end

   // request capture, scan and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         cnt_ff  <= req_page_count;
         idx_ff  <= req_frame_index;
         scan_ff <= '0;
         run_ff  <= '0;
      end
      if (cmd.scan_chk) begin
         scan_ff <= scan_ff + COUNT_W'(1);
         if (bit_rd_ff) begin
            run_ff   <= run_ff + COUNT_W'(1);
            first_ff <= first_now;
         end else begin
            run_ff <= '0;
         end
      end
      if (cmd.take_run || cmd.take_bump) begin
         start_ff <= start_value;
         walk_ff  <= COUNT_W'(start_value);
         end_ff   <= COUNT_W'(start_value) + cnt_ff;
      end
      if (cmd.fill_init) begin
         walk_ff <= COUNT_W'(idx_ff);
         end_ff  <= (free_end > SUM_W'(lim)) ? lim : free_end[COUNT_W-1:0];
      end
      if (cmd.mark_step || cmd.fill_step) begin
         walk_ff <= walk_ff + COUNT_W'(1);
      end
   end

   // memory port selection
   always_comb begin
      map_we  = cmd.clr_step || cmd.mark_step || cmd.fill_step;
      map_wa  = cmd.clr_step ? clr_ff : walk_ff[ADDR_W-1:0];
      map_wd  = cmd.fill_step;
      size_we = cmd.clr_step || cmd.take_run || cmd.take_bump;
      size_wa = cmd.clr_step ? clr_ff : start_value;
      size_wd = cmd.clr_step ? '0 : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         free_map[map_wa] <= map_wd;
      end
      if (cmd.scan_rd) begin
         bit_rd_ff <= free_map[scan_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         run_size[size_wa] <= size_wd;
      end
      if (cmd.size_rd) begin
         size_rd_ff <= run_size[idx_ff[ADDR_W-1:0]];
      end
   end

   // result and response registers
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_ok_ff     <= 1'b0;
         res_start_ff  <= '0;
         res_status_ff <= STATUS_BAD_REQ;
         unique case (cmd.res_code)
            RES_ALLOC_OK: begin
               res_ok_ff     <= 1'b1;
               res_start_ff  <= INDEX_W'(start_ff);
               res_status_ff <= STATUS_DONE;
            end
            RES_FREE_OK: begin
               res_ok_ff     <= 1'b1;
               res_status_ff <= STATUS_DONE;
            end
            RES_NO_SPACE: begin
               res_status_ff <= STATUS_NO_SPACE;
            end
            RES_BAD_REQ: begin
               res_status_ff <= STATUS_BAD_REQ;
            end
            default: begin
            end
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff     <= res_ok_ff;
         rsp_start_ff  <= res_start_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_start_frame = rsp_start_ff;
   assign rsp_status      = rsp_status_ff;

   // a waiting transaction is never overwritten
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register loaded while a transaction was pending");

   a_rsp_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff)
      else $error("response not presented after load");

   a_ok_matches_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ok_ff == (rsp_status_ff == STATUS_DONE)))
      else $error("ok flag disagrees with status");

   a_fail_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_start_ff == '0))
      else $error("failed request reports a nonzero start frame");

endmodule
`default_nettype wire

FILE: hw/rtl/contiguous_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// first-fit contiguous page-frame allocator with bump-region fallback
// ----------------------------------------------------------------------------
// usage:
//   req channel (req_valid/req_ready) carries one transaction: req_op selects
//   allocate (run of req_page_count frames) or free (run starting at
//   req_frame_index). rsp channel returns one transaction per request with
//   rsp_ok, rsp_start_frame and rsp_status.
//   csr port: frame_count at index 0, bump_base at index 1; write only while
//   no request is in flight.
// sequence:
//   allocate: each scanned frame of the free map takes a read step and a
//   check step (single read port), then each frame of the run is marked.
//   free: reads the recorded run size, then returns each frame of the run
//   to the map.
//   one request is processed at a time.
// reset: a clearing pass writes both maps one entry per cycle, over all 1024
//   entries, with req_ready low; afterwards no frame is free until freed.
// stall: a finished response waits in the output register; the next
//   request is taken meanwhile and holds in its final step until the
//   receiver takes the pending one.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator
   import cfa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_op,
   input  wire logic [COUNT_W-1:0]   req_page_count,
   input  wire logic [INDEX_W-1:0]   req_frame_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_ok,
   output logic [INDEX_W-1:0]        rsp_start_frame,
   output logic [STATUS_W-1:0]       rsp_status,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]   csr_write_data
);

   cfa_cmd_type    cmd;
   cfa_status_type stat;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_op           (req_op),
      .req_page_count   (req_page_count),
      .req_frame_index  (req_frame_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ok           (rsp_ok),
      .rsp_start_frame  (rsp_start_frame),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire

FILE: verif/contiguous_frame_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_frame_allocator_tb
// self-checking bench: drives allocate and free requests through the valid
// and ready channels, predicts every response with its own first-fit and
// bump allocator, and compares each response field by field in order
// ----------------------------------------------------------------------------
module contiguous_frame_allocator_tb;
   import cfa_pkg::*;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic                ok;
      logic [INDEX_W-1:0]  start_frame;
      logic [STATUS_W-1:0] status;
   } frame_grant_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_op;
   logic [COUNT_W-1:0]   req_page_count;
   logic [INDEX_W-1:0]   req_frame_index;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_ok;
   logic [INDEX_W-1:0]   rsp_start_frame;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COUNT_W-1:0]   csr_write_data;

   // allocator image kept by the bench
   bit                   frame_free [MAP_DEPTH];
   logic [COUNT_W-1:0]   recorded_size [MAP_DEPTH];
   int unsigned          bump_used;
   logic [COUNT_W-1:0]   cfg_frame_count;
   logic [COUNT_W-1:0]   cfg_bump_base;

   frame_grant_type      expected_grants[$];
   logic [INDEX_W-1:0]   live_runs[$];
   int                   error_count;
   int                   stall_cycles;
   bit                   no_gaps;

   contiguous_frame_allocator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_page_count  (req_page_count),
      .req_frame_index (req_frame_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_start_frame (rsp_start_frame),
      .rsp_status      (rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned usable_frames();
      int unsigned lim;
      lim = cfg_frame_count;
      if (lim > MAP_DEPTH) lim = MAP_DEPTH;
      return lim;
   endfunction

   // applies one request to the bench image and returns the response it must give
   function automatic frame_grant_type apply_frame_request(input logic op,
                                                           input logic [COUNT_W-1:0] cnt,
                                                           input logic [INDEX_W-1:0] idx);
      frame_grant_type res;
      int unsigned     lim, run, first, base_frame, stop, i;
      bit              hit;
      lim = usable_frames();
      res.ok = 1'b0;
      res.start_frame = '0;
      res.status = STATUS_DONE;
      run = 0;
      first = 0;
      hit = 1'b0;
      if (op == OP_ALLOC) begin
         if (cnt == '0) begin
            res.status = STATUS_BAD_REQ;
            return res;
         end
         for (i = 0; i < lim; i++) begin
            if (frame_free[i]) begin
               if (run == 0) first = i;
               run++;
               if (run >= cnt) begin
                  hit = 1'b1;
                  break;
               end
            end else begin
               run = 0;
            end
         end
         if (hit) begin
            base_frame = first;
         end else begin
            base_frame = cfg_bump_base + bump_used;
            if (base_frame + cnt > lim) begin
               res.status = STATUS_NO_SPACE;
               return res;
            end
            bump_used = (bump_used + cnt) & ((1 << COUNT_W) - 1);
         end
         stop = base_frame + cnt;
         if (stop > lim) stop = lim;
         for (i = base_frame; i < stop; i++) frame_free[i] = 1'b0;
         recorded_size[base_frame] = cnt;
         res.ok = 1'b1;
         res.start_frame = INDEX_W'(base_frame);
      end else begin
         if (idx >= lim) begin
            res.status = STATUS_BAD_REQ;
            return res;
         end
         stop = idx + recorded_size[idx];
         if (stop > lim) stop = lim;
         for (i = idx; i < stop; i++) frame_free[i] = 1'b1;
         res.ok = 1'b1;
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10) $display("%0t ns: %s", $realtime, what);
   endtask

   // one request transaction; valid stays up afterwards unless the next one idles
   task automatic send_request(input logic op, input logic [COUNT_W-1:0] cnt,
                               input logic [INDEX_W-1:0] idx);
      int              gap;
      frame_grant_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_page_count  <= cnt;
      req_frame_index <= idx;
      do @(posedge clock); while (!req_ready);
      res = apply_frame_request(op, cnt, idx);
      expected_grants.push_back(res);
      if (op == OP_ALLOC && res.ok) live_runs.push_back(res.start_frame);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_grants.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_FRAME_COUNT) cfg_frame_count = value;
      else cfg_bump_base = value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [COUNT_W-1:0] frames, input logic [COUNT_W-1:0] base);
      wait_idle();
      write_register(CSR_FRAME_COUNT, frames);
      write_register(CSR_BUMP_BASE, base);
   endtask

   task automatic test_bump_and_first_fit();
      send_request(OP_ALLOC, 11'd0, INDEX_W'($urandom));
      // nothing free after reset, so frame 0 comes from the bump region
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
      send_request(OP_ALLOC, 11'd2047, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd1);
      send_request(OP_FREE, COUNT_W'($urandom), 10'd0);
      send_request(OP_FREE, COUNT_W'($urandom), 10'd0);
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
      send_request(OP_ALLOC, 11'd3, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd1);
   endtask

   task automatic test_frame_limit_edges();
      configure(11'd0, 11'd0);
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd0);
      configure(11'd8, 11'd8);
      send_request(OP_ALLOC, 11'd5, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd8);
      send_request(OP_FREE, COUNT_W'($urandom), 10'd7);
      // bump base far past the managed frames
      configure(11'd2047, 11'd2047);
      send_request(OP_ALLOC, 11'd3, INDEX_W'($urandom));
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd1023);
      // bump run ending exactly on the last frame
      configure(11'd1024, 11'd1016);
      send_request(OP_ALLOC, 11'd4, INDEX_W'($urandom));
      // recorded run now reaches past the limit and gets clipped
      configure(11'd1022, 11'd1016);
      send_request(OP_FREE, COUNT_W'($urandom), 10'd1020);
      send_request(OP_FREE, COUNT_W'($urandom), 10'd1023);
      configure(11'd1, 11'd0);
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
      send_request(OP_FREE, COUNT_W'($urandom), 10'd0);
      send_request(OP_ALLOC, 11'd1, INDEX_W'($urandom));
   endtask

   task automatic random_traffic(input int items);
      int                 lim, roll, pick;
      logic [COUNT_W-1:0] cnt;
      logic [INDEX_W-1:0] idx;
      lim = usable_frames();
      repeat (items) begin
         if ($urandom_range(0, 99) < 2) wait_idle();
         roll = $urandom_range(0, 99);
         if (live_runs.size() == 0 || roll < 55) begin
            roll = $urandom_range(0, 99);
            if (roll < 78) cnt = COUNT_W'($urandom_range(1, 8));
            else if (roll < 90) cnt = COUNT_W'($urandom_range(9, 64));
            else if (roll < 94) cnt = '0;
            else cnt = COUNT_W'($urandom_range(1, 2047));
            send_request(OP_ALLOC, cnt, INDEX_W'($urandom));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               pick = $urandom_range(0, live_runs.size() - 1);
               idx = live_runs[pick];
               // some runs stay listed so they get freed twice
               if ($urandom_range(0, 4) != 0) live_runs.delete(pick);
            end else if (roll < 90 && lim > 0) begin
               idx = INDEX_W'($urandom_range(0, lim - 1));
            end else begin
               idx = INDEX_W'($urandom);
            end
            send_request(OP_FREE, COUNT_W'($urandom), idx);
         end
      end
   endtask

   task automatic test_mixed_traffic();
      logic [COUNT_W-1:0] frames;
      configure(11'd160, 11'd0);
      random_traffic(60);
      frames = COUNT_W'($urandom_range(16, 64));
      configure(frames, COUNT_W'($urandom_range(0, frames)));
      random_traffic(40);
      frames = COUNT_W'($urandom_range(1, 8));
      configure(frames, COUNT_W'($urandom_range(0, frames)));
      random_traffic(30);
      configure(11'd1024, 11'd1024);
      random_traffic(30);
      frames = COUNT_W'($urandom_range(32, 300));
      configure(frames, COUNT_W'($urandom_range(0, frames)));
      random_traffic(40);
   endtask

   task automatic test_back_to_back();
      configure(11'd512, 11'd0);
      no_gaps = 1'b1;
      random_traffic(50);
      wait_idle();
      no_gaps = 1'b0;
   endtask

   task automatic test_full_map();
      configure(11'd1024, 11'd0);
      random_traffic(20);
   endtask

   // response side: random stalls, same gap profile as the request side
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         int gap;
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      frame_grant_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            flag_error($sformatf("unexpected response ok=%0d start=%0d status=%0d",
                                 rsp_ok, rsp_start_frame, rsp_status));
         end else begin
            want = expected_grants.pop_front();
            if (rsp_ok !== want.ok || rsp_start_frame !== want.start_frame ||
                rsp_status !== want.status)
               flag_error($sformatf({"response mismatch: expected ok=%0d start=%0d ",
                                     "status=%0d, got ok=%0d start=%0d status=%0d"},
                                    want.ok, want.start_frame, want.status,
                                    rsp_ok, rsp_start_frame, rsp_status));
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("contiguous_frame_allocator_tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_op           = OP_ALLOC;
      req_page_count   = '0;
      req_frame_index  = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_FRAME_COUNT;
      csr_write_data   = '0;
      error_count      = 0;
      stall_cycles     = 0;
      no_gaps          = 1'b0;
      bump_used        = 0;
      cfg_frame_count  = FRAME_COUNT_RESET;
      cfg_bump_base    = BUMP_BASE_RESET;
      foreach (frame_free[i]) begin
         frame_free[i]    = 1'b0;
         recorded_size[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_bump_and_first_fit();
      test_frame_limit_edges();
      test_mixed_traffic();
      test_back_to_back();
      test_full_map();

      wait_idle();
      if (expected_grants.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_grants.size()));
      if (error_count == 0) $display("contiguous_frame_allocator_tb: clean");
      else $display("contiguous_frame_allocator_tb: errors");
      $finish;
   end

endmodule
